// ===== design/joystick_position_and_led_duty_top_macros.svh =====
// Assertion macros shared by the checker of the joystick position and LED duty block.
// Plain text only; nothing here depends on the package.
`ifndef JOYSTICK_POSITION_AND_LED_DUTY_TOP_MACROS_SVH
`define JOYSTICK_POSITION_AND_LED_DUTY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JPLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jpld assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JPLD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jpld assertion failed");

`endif

// ===== design/jpld_pkg.sv =====
// Package of the joystick position and LED duty block: item types, codes and constants.
// No dependencies; used by the interfaces, the top level and the checker.
package jpld_pkg;

  // Fixed arithmetic constants of the mapping.
  localparam int DEAD_ZONE     = 60;
  localparam int PWM_TOP       = 4095;
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int SQUARE_SIZE   = 8;
  localparam int MOVE_GAIN     = 5;
  localparam int MOVE_SHIFT    = 11;
  localparam int MOVE_DIV      = 2 ** MOVE_SHIFT;
  localparam int DUTY_SPAN     = MOVE_DIV - DEAD_ZONE;

  // Clamp limits of the two coordinates.
  localparam int V_MAX = SCREEN_WIDTH - SQUARE_SIZE;
  localparam int H_MAX = SCREEN_HEIGHT - SQUARE_SIZE;

  // Reciprocal of DUTY_SPAN, scaled with PWM_TOP, rounded up. Exact for all
  // inputs below DUTY_SPAN since (DUTY_SPAN - 1) squared stays below 2**DUTY_SHIFT.
  localparam int DUTY_SHIFT = 22;
  localparam longint unsigned DUTY_RECIP_L =
      (64'(PWM_TOP) * (64'd1 << DUTY_SHIFT) + 64'(DUTY_SPAN - 1)) / 64'(DUTY_SPAN);
  localparam logic [23:0] DUTY_RECIP = 24'(DUTY_RECIP_L);

  // Reset values of configuration and state.
  localparam logic [11:0] CENTER_X_RST = 12'd1922;
  localparam logic [11:0] CENTER_Y_RST = 12'd2025;
  localparam logic [6:0]  HOME_V_RST   = 7'd59;
  localparam logic [5:0]  HOME_H_RST   = 6'd29;
  localparam logic [19:0] DEBOUNCE_RST = 20'd200000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_BTN_A     = 2'd1,
    CMD_BTN_STICK = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_HOME_V   = 3'd2,
    CFG_HOME_H   = 3'd3,
    CFG_DEBOUNCE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] sample_x;
    logic [11:0] sample_y;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  square_horizontal;
    logic [6:0]  square_vertical;
    logic [11:0] red_duty;
    logic [11:0] blue_duty;
    logic [11:0] green_duty;
    logic [1:0]  border_style;
    logic        pwm_enabled;
  } out_item_t;

endpackage

// ===== design/jpld_in_if.sv =====
// Input channel of the joystick position and LED duty block: valid, ready and one item.
// Depends on jpld_pkg for the item type.
interface jpld_in_if;
  logic               valid;
  logic               ready;
  jpld_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/jpld_out_if.sv =====
// Result channel of the joystick position and LED duty block: valid, ready and one item.
// Depends on jpld_pkg for the item type.
interface jpld_out_if;
  logic                valid;
  logic                ready;
  jpld_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/joystick_position_and_led_duty_top.sv =====
// Top level of the joystick position and LED duty block.
// Depends on jpld_pkg, jpld_in_if and jpld_out_if.
//
//   Channel  Dir  Handshake        Carries
//   in_i     in   valid / ready    cmd, sample_x, sample_y, now_us
//   out_o    out  valid / ready    square position, three duties, style, PWM flag
//   cfg      in   cfg_we_i only    register index and write data, no back-pressure
//
// One item is accepted per cycle unless the input is stalled. An item waits in the input
// register until it can leave; a sample's result is loaded into the output register as
// the sample leaves, and is offered from there until it is taken.
// State is updated as an item leaves the input register. A result not taken holds the
// output register; a sample behind it waits and stalls the input, while button items still
// pass. Reset restores state and configuration and clears both valid flags at once.
module joystick_position_and_led_duty_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  jpld_in_if.sink                             in_i,
  jpld_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [jpld_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [jpld_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [11:0] center_x_q, center_y_q;
  logic [6:0]  home_v_q;
  logic [5:0]  home_h_q;
  logic [19:0] debounce_q;

  // Block state.
  logic [6:0]  pos_v_q, pos_v_d;
  logic [5:0]  pos_h_q, pos_h_d;
  logic        pwm_on_q, green_on_q;
  logic [1:0]  style_q;
  logic [31:0] last_a_q, last_stick_q;

  // Input register and output register.
  logic                s1_valid_q;
  jpld_pkg::in_item_t  s1_item_q;
  logic                out_valid_q;
  jpld_pkg::out_item_t out_item_q, out_item_d;

  logic s1_is_sample, out_free, s1_adv, in_fire;

  // Datapath signals of the item in the input register.
  logic signed [12:0] dev_x, dev_y;
  logic [11:0]        mag_x, mag_y;
  logic signed [8:0]  move_x, move_y;
  logic signed [8:0]  sum_v, sum_h;
  logic [31:0]        elapsed_a, elapsed_stick;
  logic               press_a_ok, press_stick_ok;

  // Steps a coordinate one unit toward its home.
  function automatic logic signed [8:0] step_home(logic [6:0] pos, logic [6:0] home);
    logic signed [8:0] p;
    p = $signed({2'b00, pos});
    if (pos < home) begin
      return p + 9'sd1;
    end else if (pos > home) begin
      return p - 9'sd1;
    end
    return p;
  endfunction

  // Limits a coordinate to [0, hi].
  function automatic logic [6:0] clamp_pos(logic signed [8:0] v, int hi);
    if (v < 9'sd0) begin
      return 7'd0;
    end else if (v > $signed(9'(hi))) begin
      return 7'(hi);
    end
    return v[6:0];
  endfunction

  // Scales a deviation to a movement, dev * gain / 2**shift, truncated toward zero.
  function automatic logic signed [8:0] move_of(logic signed [12:0] dev);
    logic signed [15:0] prod;
    logic signed [15:0] biased;
    prod   = 16'(dev) * $signed(16'(jpld_pkg::MOVE_GAIN));
    biased = prod + ((prod < 16'sd0) ? $signed(16'(jpld_pkg::MOVE_DIV - 1)) : 16'sd0);
    return 9'(biased >>> jpld_pkg::MOVE_SHIFT);
  endfunction

  function automatic logic [11:0] abs_of(logic signed [12:0] dev);
    return dev[12] ? 12'(-dev) : 12'(dev);
  endfunction

  // LED duty from the deviation magnitude: zero in the dead zone, a linear ramp
  // through the reciprocal multiply above it, and full scale beyond the span.
  function automatic logic [11:0] duty_of(logic [11:0] mag);
    logic [11:0] over;
    logic [34:0] prod;
    logic [11:0] duty;
    over = mag - 12'(jpld_pkg::DEAD_ZONE);
    prod = 35'(over[10:0]) * 35'(jpld_pkg::DUTY_RECIP);
    if (mag <= 12'(jpld_pkg::DEAD_ZONE)) begin
      duty = '0;
    end else if (over >= 12'(jpld_pkg::DUTY_SPAN)) begin
      duty = 12'(jpld_pkg::PWM_TOP);
    end else begin
      duty = prod[jpld_pkg::DUTY_SHIFT +: 12];
    end
    return duty;
  endfunction

  // Handshake. A button item leaves the input register at once; a sample needs
  // room in the output register, which frees up in the cycle it is taken.
  assign s1_is_sample = (s1_item_q.cmd == jpld_pkg::CMD_SAMPLE);
  assign out_free     = !out_valid_q || out_o.ready;
  assign s1_adv       = s1_valid_q && (!s1_is_sample || out_free);
  assign in_i.ready   = !s1_valid_q || s1_adv;
  assign in_fire      = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  // Centered deviations and the derived movement of each axis.
  assign dev_x  = $signed({1'b0, s1_item_q.sample_x}) - $signed({1'b0, center_x_q});
  assign dev_y  = $signed({1'b0, s1_item_q.sample_y}) - $signed({1'b0, center_y_q});
  assign mag_x  = abs_of(dev_x);
  assign mag_y  = abs_of(dev_y);
  assign move_x = move_of(dev_x);
  assign move_y = move_of(dev_y);

  // Y drives the vertical coordinate, X drives the horizontal one with its sign
  // reversed. Inside the dead zone the coordinate drifts back home.
  assign sum_v = (mag_y > 12'(jpld_pkg::DEAD_ZONE)) ? ($signed({2'b00, pos_v_q}) + move_y)
                                                   : step_home(pos_v_q, home_v_q);
  assign sum_h = (mag_x > 12'(jpld_pkg::DEAD_ZONE)) ? ($signed({3'b000, pos_h_q}) - move_x)
                                                   : step_home({1'b0, pos_h_q},
                                                               {1'b0, home_h_q});
  assign pos_v_d = clamp_pos(sum_v, jpld_pkg::V_MAX);
  assign pos_h_d = 6'(clamp_pos(sum_h, jpld_pkg::H_MAX));

  // Debounce: the time since the last accepted press wraps modulo 2**32.
  assign elapsed_a      = s1_item_q.now_us - last_a_q;
  assign elapsed_stick  = s1_item_q.now_us - last_stick_q;
  assign press_a_ok     = (elapsed_a >= {12'd0, debounce_q});
  assign press_stick_ok = (elapsed_stick >= {12'd0, debounce_q});

  always_comb begin
    out_item_d                   = '0;
    out_item_d.square_horizontal = pos_h_d;
    out_item_d.square_vertical   = pos_v_d;
    out_item_d.border_style      = style_q;
    out_item_d.pwm_enabled       = pwm_on_q;
    if (pwm_on_q) begin
      out_item_d.red_duty   = duty_of(mag_y);
      out_item_d.blue_duty  = duty_of(mag_x);
      out_item_d.green_duty = green_on_q ? 12'(jpld_pkg::PWM_TOP) : 12'd0;
    end
  end

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= jpld_pkg::CENTER_X_RST;
      center_y_q <= jpld_pkg::CENTER_Y_RST;
      home_v_q   <= jpld_pkg::HOME_V_RST;
      home_h_q   <= jpld_pkg::HOME_H_RST;
      debounce_q <= jpld_pkg::DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jpld_pkg::CFG_CENTER_X: center_x_q <= cfg_wdata_i[11:0];
        jpld_pkg::CFG_CENTER_Y: center_y_q <= cfg_wdata_i[11:0];
        jpld_pkg::CFG_HOME_V:   home_v_q   <= cfg_wdata_i[6:0];
        jpld_pkg::CFG_HOME_H:   home_h_q   <= cfg_wdata_i[5:0];
        jpld_pkg::CFG_DEBOUNCE: debounce_q <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  // Block state, updated once for each item as it leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_v_q      <= jpld_pkg::HOME_V_RST;
      pos_h_q      <= jpld_pkg::HOME_H_RST;
      pwm_on_q     <= 1'b1;
      green_on_q   <= 1'b0;
      style_q      <= 2'd1;
      last_a_q     <= '0;
      last_stick_q <= '0;
    end else if (s1_adv) begin
      case (s1_item_q.cmd)
        jpld_pkg::CMD_SAMPLE: begin
          pos_v_q <= pos_v_d;
          pos_h_q <= pos_h_d;
        end
        jpld_pkg::CMD_BTN_A: begin
          if (press_a_ok) begin
            pwm_on_q <= !pwm_on_q;
            last_a_q <= s1_item_q.now_us;
          end
        end
        jpld_pkg::CMD_BTN_STICK: begin
          if (press_stick_ok) begin
            green_on_q   <= !green_on_q;
            last_stick_q <= s1_item_q.now_us;
            case (style_q)
              2'd1:    style_q <= 2'd2;
              2'd2:    style_q <= 2'd3;
              default: style_q <= 2'd1;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_i.payload;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_is_sample) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_is_sample) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

// ===== design/jpld_checker.sv =====
// Port-level checker of the joystick position and LED duty block, bound to the top level.
// Depends on jpld_pkg and on the assertion macros header.
`include "joystick_position_and_led_duty_top_macros.svh"

module jpld_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input jpld_pkg::out_item_t out_item_i
);

  logic pwm_off_shown, duties_dark, green_legal, square_legal;

  assign pwm_off_shown = out_valid_i && !out_item_i.pwm_enabled;
  assign duties_dark   = (out_item_i.red_duty == 12'd0) && (out_item_i.blue_duty == 12'd0) &&
                         (out_item_i.green_duty == 12'd0);
  assign green_legal   = (out_item_i.green_duty == 12'd0) ||
                         (out_item_i.green_duty == 12'(jpld_pkg::PWM_TOP));
  assign square_legal  = (out_item_i.square_vertical <= 7'(jpld_pkg::V_MAX)) &&
                         (out_item_i.square_horizontal <= 6'(jpld_pkg::H_MAX)) &&
                         (out_item_i.border_style != 2'd0);

  // A stalled result stays offered and unchanged.
  `JPLD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `JPLD_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_item_i))

  // With PWM off every LED is dark.
  `JPLD_ASSERT_IMP(a_duty_off, clk_i, rst_ni, pwm_off_shown, duties_dark)

  // Green is either fully on or off.
  `JPLD_ASSERT_IMP(a_green_levels, clk_i, rst_ni, out_valid_i, green_legal)

  // The square stays on screen and the border style is never zero.
  `JPLD_ASSERT_IMP(a_square_range, clk_i, rst_ni, out_valid_i, square_legal)

endmodule

bind joystick_position_and_led_duty_top jpld_checker u_jpld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);
